[hdl/tmms_pkg.sv]
// Shared types and constants for the tensor marginal mean shift unit.
`default_nettype none
package tmms_pkg;

  localparam int MAX_DIMS_DEF     = 4;
  localparam int MAX_ELEMENTS_DEF = 256;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int REG_DIMS = 4;
  localparam int TABLE_W  = 40;
  localparam int AREA_W   = 27;
  localparam int SUM_W    = 27;
  localparam int CNT_W    = 9;
  localparam int SETA_W   = 36;
  localparam int SIZE_W   = 9;
  localparam int VALUE_W  = 19;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_FIN = 2'd1;
  localparam logic [1:0] KIND_PT  = 2'd2;
  localparam logic [1:0] KIND_SET = 2'd3;

  localparam logic [1:0] RK_POINT = 2'd0;
  localparam logic [1:0] RK_SET   = 2'd1;
  localparam logic [1:0] RK_CTRL  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PHASE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] REG_NUM_DIMS = 3'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  elem0;
    logic [7:0]  elem1;
    logic [7:0]  elem2;
    logic [7:0]  elem3;
    logic [16:0] membership;
    logic [1:0]  set_dim;
    logic [7:0]  set_element;
    logic        set_last;
  } in_beat_t;

  typedef struct packed {
    logic [18:0] value;
    logic [1:0]  result_kind;
    logic [1:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic clr_wr;
    logic rd;
    logic add_wr;
    logic div_start;
    logic div_wr;
    logic area_first;
    logic area_step;
    logic area_use;
  } lane_ctl_t;

  typedef struct packed {
    logic set_acc;
    logic set_clr;
    logic area_first;
    logic area_step;
    logic div_start;
  } merge_ctl_t;

endpackage
`default_nettype wire

[hdl/tensor_marginal_mean_shift_unit.sv]
// A set element marked last starts the set query, or gets a phase error before finalize.
// Finalize walks every table address with the per-lane restoring dividers; all lanes
// divide in parallel. The set query uses the restoring divider in the merge stage.
// Throughput: one item at a time; a result waiting on out_ready holds off the next.
// Reset: a clearing pass zeroes every bank; items wait, config lands.
`default_nettype none
module tensor_marginal_mean_shift_unit #(
  parameter int MAX_DIMS     = tmms_pkg::MAX_DIMS_DEF,
  parameter int MAX_ELEMENTS = tmms_pkg::MAX_ELEMENTS_DEF,
  parameter int FRAC_BITS    = tmms_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tmms_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tmms_pkg::out_beat_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [8:0]           cfg_data
);

  localparam int LANES = (MAX_DIMS < tmms_pkg::REG_DIMS) ? MAX_DIMS : tmms_pkg::REG_DIMS;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int AW    = $clog2(MAX_ELEMENTS);
  localparam int MW    = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
  localparam int SZ    = tmms_pkg::SIZE_W;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ADD_RD  = 4'd2;
  localparam logic [3:0] S_ADD_WR  = 4'd3;
  localparam logic [3:0] S_FIN_AR  = 4'd4;
  localparam logic [3:0] S_FIN_RD  = 4'd5;
  localparam logic [3:0] S_FIN_ST  = 4'd6;
  localparam logic [3:0] S_FIN_DIV = 4'd7;
  localparam logic [3:0] S_PT_RD   = 4'd8;
  localparam logic [3:0] S_PT_MAX  = 4'd9;
  localparam logic [3:0] S_SET_RD  = 4'd10;
  localparam logic [3:0] S_SET_ACC = 4'd11;
  localparam logic [3:0] S_SET_AR  = 4'd12;
  localparam logic [3:0] S_SET_ST  = 4'd13;
  localparam logic [3:0] S_SET_DIV = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0]            state;
  logic [3:0]            state_next;
  tmms_pkg::in_beat_t    item;
  tmms_pkg::out_beat_t   res;
  tmms_pkg::out_beat_t   res_next;
  logic                  finalized;
  logic                  fin_set;
  logic [AW-1:0]         walk;
  logic [LW-1:0]         step;
  logic [2:0]            num_dims;
  logic [SZ-1:0]         size_reg [tmms_pkg::REG_DIMS];
  logic [SZ-1:0]         size_eff [tmms_pkg::REG_DIMS];
  logic [2:0]            nd;
  logic [7:0]            elem_a [tmms_pkg::REG_DIMS];
  logic [MW-1:0]         m_ext;
  logic [MW-1:0]         m_clip;
  logic                  walk_last;
  logic                  step_last;
  logic                  set_ok;
  logic                  accept;
  logic                  load_out;

  tmms_pkg::lane_ctl_t   lctl [LANES];
  logic [AW-1:0]         laddr [LANES];
  logic [LANES-1:0][tmms_pkg::TABLE_W-1:0] lrd;
  logic [LANES-1:0]      ldone;
  logic [LANES-1:0]      pt_mask;
  tmms_pkg::merge_ctl_t  mctl;
  logic [tmms_pkg::VALUE_W-1:0] pt_value;
  logic [tmms_pkg::VALUE_W-1:0] set_value;
  logic                  set_empty;
  logic                  mdone;

  always_comb begin
    nd = (num_dims == 3'd0) ? 3'd1 : (num_dims > 3'(LANES)) ? 3'(LANES) : num_dims;
    for (int d = 0; d < tmms_pkg::REG_DIMS; d++) begin
      if (size_reg[d] == '0) begin
        size_eff[d] = SZ'(1);
      end else if (32'(size_reg[d]) > MAX_ELEMENTS) begin
        size_eff[d] = SZ'(MAX_ELEMENTS);
      end else begin
        size_eff[d] = size_reg[d];
      end
    end
    elem_a[0] = item.elem0;
    elem_a[1] = item.elem1;
    elem_a[2] = item.elem2;
    elem_a[3] = item.elem3;
    m_ext     = MW'(item.membership);
    m_clip    = (m_ext > MW'(1 << FRAC_BITS)) ? MW'(1 << FRAC_BITS) : m_ext;
    walk_last = walk == AW'(MAX_ELEMENTS - 1);
    step_last = step == LW'(LANES - 1);
    set_ok    = finalized && {1'b0, item.set_dim} < nd &&
                {1'b0, item.set_element} < size_eff[item.set_dim];
    accept    = in_valid && in_ready;
    load_out  = state == S_EMIT && (!out_valid || out_ready);
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    mctl = '0;
    for (int l = 0; l < LANES; l++) begin
      lctl[l] = '0;
      pt_mask[l] = 3'(l) < nd && {1'b0, elem_a[l]} < size_eff[l];
      unique case (state) inside
        S_CLEAR, S_FIN_AR, S_FIN_RD, S_FIN_ST, S_FIN_DIV: laddr[l] = walk;
        S_SET_RD: laddr[l] = AW'(item.set_element);
        default: laddr[l] = AW'(elem_a[l]);
      endcase
      unique case (state) inside
        S_CLEAR: lctl[l].clr_wr = 1'b1;
        S_ADD_RD, S_PT_RD, S_SET_RD, S_FIN_RD: lctl[l].rd = 1'b1;
        S_ADD_WR: lctl[l].add_wr = pt_mask[l];
        S_FIN_AR: begin
          lctl[l].area_step  = 1'b1;
          lctl[l].area_first = step == '0;
          lctl[l].area_use   = {1'b0, step} < nd && step != LW'(l);
        end
        S_FIN_ST: lctl[l].div_start = 1'b1;
        S_FIN_DIV: lctl[l].div_wr = 3'(l) < nd && 32'(walk) < 32'(size_eff[l]);
        default: lctl[l] = '0;
      endcase
    end
    unique case (state)
      S_SET_ACC: begin
        mctl.set_acc = set_ok;
        mctl.set_clr = item.set_last && !finalized;
      end
      S_SET_AR: begin
        mctl.area_step  = 1'b1;
        mctl.area_first = step == '0;
      end
      S_SET_ST: mctl.div_start = 1'b1;
      S_SET_DIV: mctl.set_clr = mdone;
      default: mctl = '0;
    endcase
  end

  generate
    for (genvar g = 0; g < LANES; g++) begin : g_lane
      tmms_lane #(.MAX_ELEMENTS(MAX_ELEMENTS), .AW(AW)) u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctl      (lctl[g]),
        .addr     (laddr[g]),
        .add_val  (tmms_pkg::TABLE_W'(m_clip)),
        .factor   (size_eff[step]),
        .rd_data  (lrd[g]),
        .div_done (ldone[g])
      );
    end
  endgenerate

  tmms_merge #(.LANES(LANES), .FRAC_BITS(FRAC_BITS), .LW(LW)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .nd        (nd),
    .step      (step),
    .set_dim   (item.set_dim),
    .rd_data   (lrd),
    .pt_mask   (pt_mask),
    .pt_value  (pt_value),
    .set_value (set_value),
    .set_empty (set_empty),
    .div_done  (mdone)
  );

  always_comb begin
    state_next = state;
    res_next   = res;
    fin_set    = 1'b0;
    unique case (state)
      S_CLEAR: if (walk_last) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.kind) inside
            tmms_pkg::KIND_ADD, tmms_pkg::KIND_FIN: begin
              if (finalized) begin
                res_next   = '{19'd0, tmms_pkg::RK_CTRL, tmms_pkg::ST_PHASE};
                state_next = S_EMIT;
              end else begin
                state_next = (in_data.kind == tmms_pkg::KIND_ADD) ? S_ADD_RD : S_FIN_AR;
              end
            end
            tmms_pkg::KIND_PT: begin
              if (!finalized) begin
                res_next   = '{19'd0, tmms_pkg::RK_POINT, tmms_pkg::ST_PHASE};
                state_next = S_EMIT;
              end else begin
                state_next = S_PT_RD;
              end
            end
            default: state_next = S_SET_RD;
          endcase
        end
      end
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: state_next = S_IDLE;
      S_FIN_AR: if (step_last) state_next = S_FIN_RD;
      S_FIN_RD: state_next = S_FIN_ST;
      S_FIN_ST: state_next = S_FIN_DIV;
      S_FIN_DIV: begin
        if (ldone[0]) begin
          if (walk_last) begin
            fin_set    = 1'b1;
            res_next   = '{19'd0, tmms_pkg::RK_CTRL, tmms_pkg::ST_OK};
            state_next = S_EMIT;
          end else begin
            state_next = S_FIN_RD;
          end
        end
      end
      S_PT_RD: state_next = S_PT_MAX;
      S_PT_MAX: begin
        res_next   = '{pt_value, tmms_pkg::RK_POINT, tmms_pkg::ST_OK};
        state_next = S_EMIT;
      end
      S_SET_RD: state_next = S_SET_ACC;
      S_SET_ACC: begin
        if (!item.set_last) begin
          state_next = S_IDLE;
        end else if (!finalized) begin
          res_next   = '{19'd0, tmms_pkg::RK_SET, tmms_pkg::ST_PHASE};
          state_next = S_EMIT;
        end else begin
          state_next = S_SET_AR;
        end
      end
      S_SET_AR: if (step_last) state_next = S_SET_ST;
      S_SET_ST: state_next = S_SET_DIV;
      S_SET_DIV: begin
        if (mdone) begin
          res_next   = '{set_value, tmms_pkg::RK_SET,
                         set_empty ? tmms_pkg::ST_EMPTY : tmms_pkg::ST_OK};
          state_next = S_EMIT;
        end
      end
      S_EMIT: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      finalized <= 1'b0;
      walk      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
      num_dims  <= 3'd3;
      size_reg[0] <= SZ'(256);
      size_reg[1] <= SZ'(256);
      size_reg[2] <= SZ'(256);
      size_reg[3] <= SZ'(1);
    end else begin
      state <= state_next;
      if (fin_set) finalized <= 1'b1;
      if (state == S_CLEAR || (state == S_FIN_DIV && ldone[0])) begin
        walk <= walk_last ? '0 : walk + 1'b1;
      end
      if (state == S_FIN_AR || state == S_SET_AR) begin
        step <= step_last ? '0 : step + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == tmms_pkg::REG_NUM_DIMS) begin
          num_dims <= cfg_data[2:0];
        end else if (cfg_index <= 3'(tmms_pkg::REG_DIMS)) begin
          size_reg[2'(cfg_index - 3'd1)] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= in_data;
    res <= res_next;
    if (load_out) out_data <= res_next;
  end

  a_fin_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(finalized) |-> $past(state) == S_FIN_DIV)
    else $error("finalized set outside finalize walk");

  a_ok_needs_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == tmms_pkg::ST_OK &&
    out_data.result_kind != tmms_pkg::RK_CTRL |-> finalized)
    else $error("query answered ok before finalize");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != tmms_pkg::ST_OK |-> out_data.value == '0)
    else $error("nonzero value on error result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !accept)
    else $error("item accepted while busy");

endmodule
`default_nettype wire

[hdl/tmms_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tmms_div #(
  parameter int NW = 40,
  parameter int DW = 27
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_next;
  logic          ge;

  always_comb begin
    rem_sh   = {rem, quotient[NW-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? rem_sh - {1'b0, dvs} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= rem_next[DW-1:0];
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[hdl/tmms_lane.sv]
// One dimension lane: table bank, area product and finalize divider.
`default_nettype none
module tmms_lane #(
  parameter int MAX_ELEMENTS = tmms_pkg::MAX_ELEMENTS_DEF,
  parameter int AW           = $clog2(MAX_ELEMENTS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tmms_pkg::lane_ctl_t           ctl,
  input  wire logic [AW-1:0]                 addr,
  input  wire logic [tmms_pkg::TABLE_W-1:0]  add_val,
  input  wire logic [tmms_pkg::SIZE_W-1:0]   factor,
  output logic [tmms_pkg::TABLE_W-1:0]       rd_data,
  output logic                               div_done
);

  localparam int TW = tmms_pkg::TABLE_W;

  logic [TW-1:0] mem [MAX_ELEMENTS];
  logic [tmms_pkg::AREA_W-1:0] area;
  logic [tmms_pkg::AREA_W-1:0] area_base;
  logic [tmms_pkg::AREA_W-1:0] area_next;
  logic [TW:0]   sum;
  logic [TW-1:0] quot;
  logic [TW-1:0] wdata;
  logic          we;

  tmms_div #(.NW(TW), .DW(tmms_pkg::AREA_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (rd_data),
    .divisor  (area),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    area_base = ctl.area_first ? tmms_pkg::AREA_W'(1) : area;
    area_next = ctl.area_use
              ? tmms_pkg::AREA_W'(area_base * tmms_pkg::AREA_W'(factor))
              : area_base;
    sum = {1'b0, rd_data} + {1'b0, add_val};
    we  = ctl.clr_wr | ctl.add_wr | (ctl.div_wr & div_done);
    if (ctl.clr_wr) begin
      wdata = '0;
    end else if (ctl.add_wr) begin
      wdata = sum[TW] ? '1 : sum[TW-1:0];
    end else begin
      wdata = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.area_step) area <= area_next;
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (ctl.rd) rd_data <= mem[addr];
  end

endmodule
`default_nettype wire

[hdl/tmms_merge.sv]
// Merge stage: point maximum over lanes and set-query accumulation and divide.
`default_nettype none
module tmms_merge #(
  parameter int LANES     = tmms_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = tmms_pkg::FRAC_BITS_DEF,
  parameter int LW        = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire tmms_pkg::merge_ctl_t                   ctl,
  input  wire logic [2:0]                             nd,
  input  wire logic [LW-1:0]                          step,
  input  wire logic [1:0]                             set_dim,
  input  wire logic [LANES-1:0][tmms_pkg::TABLE_W-1:0] rd_data,
  input  wire logic [LANES-1:0]                       pt_mask,
  output logic [tmms_pkg::VALUE_W-1:0]                pt_value,
  output logic [tmms_pkg::VALUE_W-1:0]                set_value,
  output logic                                        set_empty,
  output logic                                        div_done
);

  localparam int TW      = tmms_pkg::TABLE_W;
  localparam int SW      = tmms_pkg::SUM_W;
  localparam int CAP_RAW = 4 << FRAC_BITS;
  localparam int CAP     = (CAP_RAW > 524287) ? 524287 : CAP_RAW;
  localparam logic [TW-1:0] CAP_T = TW'(CAP);
  localparam logic [TW:0]   SUM_MAX = (TW + 1)'((64'd1 << SW) - 64'd1);

  logic [SW-1:0]               set_sum;
  logic [tmms_pkg::CNT_W-1:0]  cnt [LANES];
  logic [tmms_pkg::SETA_W-1:0] area;
  logic [tmms_pkg::SETA_W-1:0] area_base;
  logic [TW-1:0]               best;
  logic [TW-1:0]               v;
  logic [TW:0]                 acc;
  logic [SW-1:0]               quot;
  logic [LW-1:0]               sd;

  tmms_div #(.NW(SW), .DW(tmms_pkg::SETA_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (set_sum),
    .divisor  (area),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    best = '0;
    for (int l = 0; l < LANES; l++) begin
      if (pt_mask[l] && rd_data[l] > best) best = rd_data[l];
    end
    pt_value = (best > CAP_T) ? tmms_pkg::VALUE_W'(CAP) : best[tmms_pkg::VALUE_W-1:0];
  end

  always_comb begin
    set_empty = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (3'(l) < nd && cnt[l] == '0) set_empty = 1'b1;
    end
    set_value = (set_empty || {{(TW-SW){1'b0}}, quot} > CAP_T) ?
                (set_empty ? '0 : tmms_pkg::VALUE_W'(CAP)) :
                tmms_pkg::VALUE_W'(quot);
  end

  always_comb begin
    sd        = LW'(set_dim);
    v         = rd_data[sd];
    acc       = (TW + 1)'(set_sum) + {1'b0, v};
    area_base = ctl.area_first ? tmms_pkg::SETA_W'(1) : area;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.set_clr) begin
      set_sum <= '0;
      for (int l = 0; l < LANES; l++) cnt[l] <= '0;
    end else if (ctl.set_acc) begin
      set_sum <= (acc > SUM_MAX) ? SUM_MAX[SW-1:0] : acc[SW-1:0];
      if (cnt[sd] != '1) cnt[sd] <= cnt[sd] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.area_step) begin
      if ({{(3-LW){1'b0}}, step} < nd && LW <= 3) begin
        area <= tmms_pkg::SETA_W'(area_base * tmms_pkg::SETA_W'(cnt[step]));
      end else begin
        area <= area_base;
      end
    end
  end

endmodule
`default_nettype wire
